>>> design/stl_pkg.sv
// Shared types, codes and character classifiers for the source token lexer.
package stl_pkg;

    // Event codes of one result
    localparam logic [2:0] EV_TEXT     = 3'd0;
    localparam logic [2:0] EV_TEXT_END = 3'd1;
    localparam logic [2:0] EV_END      = 3'd2;
    localparam logic [2:0] EV_ERROR    = 3'd3;
    localparam logic [2:0] EV_DONE     = 3'd4;

    // Token types
    localparam logic [3:0] TT_INT    = 4'd0;
    localparam logic [3:0] TT_BYTE   = 4'd1;
    localparam logic [3:0] TT_ID     = 4'd2;
    localparam logic [3:0] TT_STR    = 4'd3;
    localparam logic [3:0] TT_CHAR   = 4'd4;
    localparam logic [3:0] TT_LPAREN = 4'd5;
    localparam logic [3:0] TT_RPAREN = 4'd6;
    localparam logic [3:0] TT_LBRACE = 4'd7;
    localparam logic [3:0] TT_RBRACE = 4'd8;
    localparam logic [3:0] TT_SEMI   = 4'd9;
    localparam logic [3:0] TT_COLON  = 4'd10;
    localparam logic [3:0] TT_COMMA  = 4'd11;
    localparam logic [3:0] TT_LBRACK = 4'd12;
    localparam logic [3:0] TT_RBRACK = 4'd13;
    localparam logic [3:0] TT_OP     = 4'd14;
    localparam logic [3:0] TT_ARROW  = 4'd15;

    // Error codes
    localparam logic [1:0] ERR_BYTE_RANGE = 2'd0;
    localparam logic [1:0] ERR_CHAR_EOF   = 2'd1;
    localparam logic [1:0] ERR_CHAR_QUOTE = 2'd2;

    // Input kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [31:0] BYTE_LIT_MAX = 32'd255;
    localparam logic [15:0] LINE_MAX     = 16'hFFFF;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        M_IDLE,
        M_NUM,
        M_IDENT,
        M_STR,
        M_OPP,
        M_CH_OPEN,
        M_CH_ESC,
        M_CH_CLOSE
    } t_mode;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  tok_type;
        logic [7:0]  text_byte;
        logic [31:0] tok_value;
        logic [15:0] tok_line;
        logic [1:0]  err_code;
        logic        last;
    } t_res;

    // Results of one input item; r1 is used only when two is set
    typedef struct packed {
        logic two;
        t_res r0;
        t_res r1;
    } t_pair;

    // What a byte does when it opens a new token
    typedef struct packed {
        t_mode      mode;
        logic       set_op;
        logic       set_acc;
        logic       line_inc;
        logic       emit;
        logic [2:0] ev;
        logic [3:0] typ;
    } t_start;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_op_char(input logic [7:0] c);
        return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
               (c == "=") || (c == "%") || (c == "|") || (c == "&") ||
               (c == "!") || (c == "<") || (c == ">") || (c == ".");
    endfunction

    function automatic t_res mk_res(input logic [2:0] ev, input logic [3:0] typ,
                                    input logic [7:0] text, input logic [31:0] value,
                                    input logic [1:0] err, input logic [15:0] line);
        t_res r;
        r.event_res = ev;
        r.tok_type  = typ;
        r.text_byte = text;
        r.tok_value = value;
        r.tok_line  = line;
        r.err_code  = err;
        r.last      = 1'b0;
        return r;
    endfunction

    // Classify a byte seen with no token open
    function automatic t_start start_class(input logic [7:0] c);
        t_start s;
        s = '{mode: M_IDLE, set_op: 1'b0, set_acc: 1'b0, line_inc: 1'b0,
              emit: 1'b0, ev: EV_TEXT, typ: TT_INT};
        if (!c[7]) begin
            if (is_space(c)) begin
                s.line_inc = (c == 8'd10);
            end else if (is_digit(c)) begin
                s.mode    = M_NUM;
                s.set_acc = 1'b1;
                s.emit    = 1'b1;
            end else if (is_alpha(c) || (c == "_")) begin
                s.mode = M_IDENT;
                s.emit = 1'b1;
                s.typ  = TT_ID;
            end else if (c == "\"") begin
                s.mode = M_STR;
            end else if (c == "'") begin
                s.mode = M_CH_OPEN;
            end else if (is_op_char(c)) begin
                s.mode   = M_OPP;
                s.set_op = 1'b1;
            end else begin
                s.ev = EV_TEXT_END;
                unique case (c)
                    "(": begin s.emit = 1'b1; s.typ = TT_LPAREN; end
                    ")": begin s.emit = 1'b1; s.typ = TT_RPAREN; end
                    "{": begin s.emit = 1'b1; s.typ = TT_LBRACE; end
                    "}": begin s.emit = 1'b1; s.typ = TT_RBRACE; end
                    ";": begin s.emit = 1'b1; s.typ = TT_SEMI; end
                    ":": begin s.emit = 1'b1; s.typ = TT_COLON; end
                    ",": begin s.emit = 1'b1; s.typ = TT_COMMA; end
                    "[": begin s.emit = 1'b1; s.typ = TT_LBRACK; end
                    "]": begin s.emit = 1'b1; s.typ = TT_RBRACK; end
                    default: s.emit = 1'b0;
                endcase
            end
        end
        return s;
    endfunction

endpackage

>>> design/stl_front.sv
// Lexer front end: scan state machine that turns one byte into up to two results.
module stl_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  stl_pkg::t_in   i_item,
    output logic           o_push,
    output stl_pkg::t_pair o_pair
);

    stl_pkg::t_mode r_mode, n_mode;
    logic [7:0]     r_op, n_op;
    logic [31:0]    r_acc, n_acc;
    logic [7:0]     r_char, n_char;
    logic [15:0]    r_line, n_line;
    logic           r_halt, n_halt;

    logic [7:0]     c;
    logic           is_end;
    logic           dig;
    logic           idch;
    logic           join_op;
    logic           arrow;
    logic           do_start;
    logic [35:0]    acc_x10;
    logic [31:0]    acc_next;
    stl_pkg::t_start st;

    stl_pkg::t_res  res0, res1;
    logic [1:0]     cnt;

    assign c      = i_item.in_byte;
    assign is_end = (i_item.kind == stl_pkg::KIND_END);
    assign dig    = stl_pkg::is_digit(c);
    assign idch   = stl_pkg::is_ident(c);
    assign st     = stl_pkg::start_class(c);
    assign arrow  = (r_op == "-") && (c == ">");
    assign join_op = (c == "=") || ((r_op == "|") && (c == "|")) ||
                     ((r_op == "&") && (c == "&")) || arrow;

    // acc * 10 + digit, saturated to 32 bits
    assign acc_x10  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {32'd0, c[3:0]};
    assign acc_next = (|acc_x10[35:32]) ? '1 : acc_x10[31:0];

    // byte closes the open token (if any) and is then scanned as a fresh byte
    assign do_start = !is_end && !r_halt &&
                      ((r_mode == stl_pkg::M_IDLE) ||
                       ((r_mode == stl_pkg::M_NUM) && !dig && (c != "b")) ||
                       ((r_mode == stl_pkg::M_IDENT) && !idch) ||
                       ((r_mode == stl_pkg::M_OPP) && !join_op));

    // Next state
    always_comb begin
        n_mode = r_mode;
        n_op   = r_op;
        n_acc  = r_acc;
        n_char = r_char;
        n_line = r_line;
        n_halt = r_halt;
        if (is_end) begin
            n_mode = stl_pkg::M_IDLE;
            n_op   = '0;
            n_acc  = '0;
            n_char = '0;
            n_line = 16'd1;
            n_halt = 1'b0;
        end else if (!r_halt) begin
            unique case (r_mode)
                stl_pkg::M_NUM: begin
                    if (dig) begin
                        n_acc = acc_next;
                    end else if (c == "b") begin
                        n_mode = stl_pkg::M_IDLE;
                        n_halt = (r_acc > stl_pkg::BYTE_LIT_MAX);
                    end
                end
                stl_pkg::M_STR: begin
                    if (c == "\"") begin
                        n_mode = stl_pkg::M_IDLE;
                    end
                end
                stl_pkg::M_OPP: begin
                    if (join_op) begin
                        n_mode = stl_pkg::M_IDLE;
                    end
                end
                stl_pkg::M_CH_OPEN: begin
                    if (!c[7]) begin
                        if (c == "\\") begin
                            n_mode = stl_pkg::M_CH_ESC;
                        end else begin
                            n_char = c;
                            n_mode = stl_pkg::M_CH_CLOSE;
                        end
                    end
                end
                stl_pkg::M_CH_ESC: begin
                    if (!c[7]) begin
                        case (c)
                            "n":     n_char = 8'd10;
                            "t":     n_char = 8'd9;
                            "r":     n_char = 8'd13;
                            "0":     n_char = 8'd0;
                            default: n_char = c;
                        endcase
                        n_mode = stl_pkg::M_CH_CLOSE;
                    end
                end
                stl_pkg::M_CH_CLOSE: begin
                    if (!c[7]) begin
                        n_mode = stl_pkg::M_IDLE;
                        n_halt = (c != "'");
                    end
                end
                default: begin
                    n_mode = r_mode;   // idle and identifier: handled by do_start
                end
            endcase
            if (do_start) begin
                n_mode = st.mode;
                if (st.set_op) begin
                    n_op = c;
                end
                if (st.set_acc) begin
                    n_acc = {28'd0, c[3:0]};
                end
                if (st.line_inc && (r_line != stl_pkg::LINE_MAX)) begin
                    n_line = r_line + 16'd1;
                end
            end
        end
    end

    // Outputs: results of this byte, in order
    always_comb begin
        stl_pkg::t_res extra;
        logic          has_extra;
        res0      = stl_pkg::mk_res(stl_pkg::EV_TEXT, stl_pkg::TT_INT, 8'd0, 32'd0,
                                    stl_pkg::ERR_BYTE_RANGE, r_line);
        res1      = res0;
        extra     = res0;
        has_extra = 1'b0;
        cnt       = 2'd0;
        if (is_end) begin
            if (!r_halt) begin
                cnt = 2'd1;
                unique case (r_mode)
                    stl_pkg::M_NUM:
                        res0 = stl_pkg::mk_res(stl_pkg::EV_END, stl_pkg::TT_INT, 8'd0, r_acc,
                                               stl_pkg::ERR_BYTE_RANGE, r_line);
                    stl_pkg::M_IDENT:
                        res0 = stl_pkg::mk_res(stl_pkg::EV_END, stl_pkg::TT_ID, 8'd0, 32'd0,
                                               stl_pkg::ERR_BYTE_RANGE, r_line);
                    stl_pkg::M_STR:
                        res0 = stl_pkg::mk_res(stl_pkg::EV_END, stl_pkg::TT_STR, 8'd0, 32'd0,
                                               stl_pkg::ERR_BYTE_RANGE, r_line);
                    stl_pkg::M_OPP:
                        res0 = stl_pkg::mk_res(stl_pkg::EV_TEXT_END, stl_pkg::TT_OP, r_op,
                                               32'd0, stl_pkg::ERR_BYTE_RANGE, r_line);
                    stl_pkg::M_CH_OPEN, stl_pkg::M_CH_ESC:
                        res0 = stl_pkg::mk_res(stl_pkg::EV_ERROR, stl_pkg::TT_CHAR, 8'd0,
                                               32'd0, stl_pkg::ERR_CHAR_EOF, r_line);
                    stl_pkg::M_CH_CLOSE:
                        res0 = stl_pkg::mk_res(stl_pkg::EV_ERROR, stl_pkg::TT_CHAR, 8'd0,
                                               32'd0, stl_pkg::ERR_CHAR_QUOTE, r_line);
                    default:
                        cnt = 2'd0;
                endcase
            end
            has_extra = 1'b1;
            extra     = stl_pkg::mk_res(stl_pkg::EV_DONE, stl_pkg::TT_INT, 8'd0, 32'd0,
                                        stl_pkg::ERR_BYTE_RANGE, r_line);
        end else if (!r_halt) begin
            unique case (r_mode)
                stl_pkg::M_NUM: begin
                    cnt = 2'd1;
                    if (dig) begin
                        res0 = stl_pkg::mk_res(stl_pkg::EV_TEXT, stl_pkg::TT_INT, c, 32'd0,
                                               stl_pkg::ERR_BYTE_RANGE, r_line);
                    end else if (c == "b") begin
                        if (r_acc > stl_pkg::BYTE_LIT_MAX) begin
                            res0 = stl_pkg::mk_res(stl_pkg::EV_ERROR, stl_pkg::TT_BYTE, 8'd0,
                                                   32'd0, stl_pkg::ERR_BYTE_RANGE, r_line);
                        end else begin
                            res0 = stl_pkg::mk_res(stl_pkg::EV_END, stl_pkg::TT_BYTE, 8'd0,
                                                   r_acc, stl_pkg::ERR_BYTE_RANGE, r_line);
                        end
                    end else begin
                        res0 = stl_pkg::mk_res(stl_pkg::EV_END, stl_pkg::TT_INT, 8'd0, r_acc,
                                               stl_pkg::ERR_BYTE_RANGE, r_line);
                    end
                end
                stl_pkg::M_IDENT: begin
                    cnt = 2'd1;
                    if (idch) begin
                        res0 = stl_pkg::mk_res(stl_pkg::EV_TEXT, stl_pkg::TT_ID, c, 32'd0,
                                               stl_pkg::ERR_BYTE_RANGE, r_line);
                    end else begin
                        res0 = stl_pkg::mk_res(stl_pkg::EV_END, stl_pkg::TT_ID, 8'd0, 32'd0,
                                               stl_pkg::ERR_BYTE_RANGE, r_line);
                    end
                end
                stl_pkg::M_STR: begin
                    if (c == "\"") begin
                        cnt  = 2'd1;
                        res0 = stl_pkg::mk_res(stl_pkg::EV_END, stl_pkg::TT_STR, 8'd0, 32'd0,
                                               stl_pkg::ERR_BYTE_RANGE, r_line);
                    end else if (!c[7]) begin
                        cnt  = 2'd1;
                        res0 = stl_pkg::mk_res(stl_pkg::EV_TEXT, stl_pkg::TT_STR, c, 32'd0,
                                               stl_pkg::ERR_BYTE_RANGE, r_line);
                    end
                end
                stl_pkg::M_OPP: begin
                    if (join_op) begin
                        cnt  = 2'd2;
                        res0 = stl_pkg::mk_res(stl_pkg::EV_TEXT,
                                               arrow ? stl_pkg::TT_ARROW : stl_pkg::TT_OP,
                                               r_op, 32'd0, stl_pkg::ERR_BYTE_RANGE, r_line);
                        res1 = stl_pkg::mk_res(stl_pkg::EV_TEXT_END,
                                               arrow ? stl_pkg::TT_ARROW : stl_pkg::TT_OP,
                                               c, 32'd0, stl_pkg::ERR_BYTE_RANGE, r_line);
                    end else begin
                        cnt  = 2'd1;
                        res0 = stl_pkg::mk_res(stl_pkg::EV_TEXT_END, stl_pkg::TT_OP, r_op,
                                               32'd0, stl_pkg::ERR_BYTE_RANGE, r_line);
                    end
                end
                stl_pkg::M_CH_CLOSE: begin
                    if (!c[7]) begin
                        cnt = 2'd1;
                        if (c == "'") begin
                            res0 = stl_pkg::mk_res(stl_pkg::EV_END, stl_pkg::TT_CHAR, 8'd0,
                                                   {24'd0, r_char},
                                                   stl_pkg::ERR_BYTE_RANGE, r_line);
                        end else begin
                            res0 = stl_pkg::mk_res(stl_pkg::EV_ERROR, stl_pkg::TT_CHAR, 8'd0,
                                                   32'd0, stl_pkg::ERR_CHAR_QUOTE, r_line);
                        end
                    end
                end
                default: begin
                    cnt = 2'd0;   // idle and char-literal body emit nothing here
                end
            endcase
            if (do_start && st.emit) begin
                has_extra = 1'b1;
                extra     = stl_pkg::mk_res(st.ev, st.typ, c, 32'd0,
                                            stl_pkg::ERR_BYTE_RANGE, r_line);
            end
        end
        if (has_extra) begin
            if (cnt == 2'd0) begin
                res0 = extra;
            end else begin
                res1 = extra;
            end
            cnt = cnt + 2'd1;
        end
        if (cnt == 2'd2) begin
            res1.last = 1'b1;
        end else begin
            res0.last = 1'b1;
        end
    end

    assign o_push     = i_accept && (cnt != 2'd0);
    assign o_pair.two = (cnt == 2'd2);
    assign o_pair.r0  = res0;
    assign o_pair.r1  = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stl_pkg::M_IDLE;
            r_op   <= '0;
            r_acc  <= '0;
            r_char <= '0;
            r_line <= 16'd1;
            r_halt <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_op   <= n_op;
            r_acc  <= n_acc;
            r_char <= n_char;
            r_line <= n_line;
            r_halt <= n_halt;
        end
    end

endmodule

>>> design/stl_queue.sv
// Short queue of per-byte result groups between the scanner and the output stage.
module stl_queue #(
    parameter int DEPTH = stl_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  stl_pkg::t_pair i_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output stl_pkg::t_pair o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    stl_pkg::t_pair mem [DEPTH];

    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

>>> design/stl_back.sv
// Output stage: registers one result group and hands its results out one per pop.
module stl_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  stl_pkg::t_pair i_q_data,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output stl_pkg::t_res  o_res
);

    logic           r_valid;
    logic           r_second;
    stl_pkg::t_pair r_pair;
    logic           take;
    logic           group_done;
    logic           load;

    assign o_empty    = !r_valid;
    assign o_res      = r_second ? r_pair.r1 : r_pair.r0;
    assign take       = i_pop && r_valid;
    assign group_done = take && (!r_pair.two || r_second);
    assign load       = (!r_valid || group_done) && !i_q_empty;
    assign o_q_pop    = load;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pair <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= 1'b1;
            r_second <= 1'b0;
        end else if (group_done) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= 1'b1;
        end
    end

endmodule

>>> design/source_token_lexer.sv
// Top level of the source token lexer: scanner, result queue and output stage.
//
// Usage:
//   Input channel (queue style): drive i_in {kind, in_byte} and raise i_push;
//   a transaction completes at a rising edge with i_push high and o_full low.
//   kind 0 carries one program byte, kind 1 marks end of program.
//   Result channel: while o_empty is low, o_res holds the oldest result; a
//   transaction completes at a rising edge with i_pop high and o_empty low.
//   Results of one input transaction come out in order; o_res.last marks the
//   final one. A byte makes zero, one or two results.
// Timing:
//   The scanner takes one byte per cycle while o_full is low and pushes its
//   results, as one group, into a QUEUE_DEPTH-entry queue at the accepting
//   edge; the output stage then registers the group and drives o_res from
//   that register. One result leaves per cycle while i_pop is high, so the
//   sustained rate is one byte per cycle, lower only while bytes yield two
//   results (e.g. joined operators, or a token closed by a token start).
// Stall: if the receiver holds i_pop low, the queue fills and o_full rises;
//   bytes that make no result are then held too. Nothing is dropped.
// Reset: i_rst_n low at a clock edge clears scan state (line count to 1),
//   empties the queue and the output stage. No clearing pass is needed.
module source_token_lexer #(
    parameter int QUEUE_DEPTH = stl_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  stl_pkg::t_in  i_in,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output stl_pkg::t_res o_res
);

    logic           accept;
    logic           f_push;
    stl_pkg::t_pair f_pair;
    logic           q_empty;
    logic           q_pop;
    stl_pkg::t_pair q_data;

    // Full is conservative: a byte waits while the queue is full even if it
    // would produce no result.
    assign accept = i_push && !o_full;

    stl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in),
        .o_push   (f_push),
        .o_pair   (f_pair)
    );

    stl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_pair),
        .i_pop   (q_pop),
        .o_full  (o_full),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    stl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_res     (o_res)
    );

endmodule

>>> design/stl_checker.sv
// Port-level checks for the source token lexer, bound to the top level.
module stl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_push,
    input stl_pkg::t_in  i_in,
    input logic          o_full,
    input logic          i_pop,
    input logic          o_empty,
    input stl_pkg::t_res o_res
);

    // After reset the result side starts empty
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> o_empty)
        else $error("result queue not empty after reset");

    // A waiting result that is not popped stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_res)))
        else $error("stalled result changed");

    // An offered transaction that is held back keeps its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |=> (i_push && $stable(i_in)))
        else $error("held input transaction changed");

    // Program done is always the final result of its transaction
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_res.event_res == stl_pkg::EV_DONE)) |-> o_res.last)
        else $error("program done without last");

    // Line count never reads zero and events stay in range
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> ((o_res.tok_line != 16'd0) && (o_res.event_res <= stl_pkg::EV_DONE)))
        else $error("result field out of range");

endmodule

bind source_token_lexer stl_checker u_stl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_push  (i_push),
    .i_in    (i_in),
    .o_full  (o_full),
    .i_pop   (i_pop),
    .o_empty (o_empty),
    .o_res   (o_res)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the source token lexer: random C-like programs against a predictor.
module testbench;
    import stl_pkg::*;

    // Cycles without any transaction on either side before the run is abandoned.
    // The slowest legal gap is a long random stall (83 in 100) on one side, which
    // practically never comes near this limit.
    localparam int QUIET_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 175;

    // Predicts the token events of the lexer and checks what comes out.
    class lexer_tracker;
        t_mode       mode;
        logic [7:0]  op_ch;     // operator character waiting for a partner
        logic [31:0] num_val;   // saturating decimal value of the open number
        logic [7:0]  chr_val;   // decoded character literal
        logic [15:0] line_no;
        bit          halted;    // an error was reported, wait for end of program
        t_res        owed[$];   // token events the block still has to deliver
        t_res        step[$];   // events caused by the current byte
        int          mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            mode    = M_IDLE;
            op_ch   = '0;
            num_val = '0;
            chr_val = '0;
            line_no = 16'd1;
            halted  = 1'b0;
        endfunction

        function bit ch_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit ch_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit ch_blank(logic [7:0] c);
            return c == " " || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function bit ch_oper(logic [7:0] c);
            case (c)
                "+", "-", "*", "/", "=", "%", "|", "&", "!", "<", ">", ".": return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // Token type of a punctuation byte; TT_INT means the byte is no punctuation
        function logic [3:0] punct_kind(logic [7:0] c);
            case (c)
                "(": return TT_LPAREN;
                ")": return TT_RPAREN;
                "{": return TT_LBRACE;
                "}": return TT_RBRACE;
                ";": return TT_SEMI;
                ":": return TT_COLON;
                ",": return TT_COMMA;
                "[": return TT_LBRACK;
                "]": return TT_RBRACK;
                default: return TT_INT;
            endcase
        endfunction

        function void put(logic [2:0] ev, logic [3:0] typ, logic [7:0] text,
                          logic [31:0] value, logic [1:0] err);
            t_res r;
            if (step.size() >= 2) return;
            r           = '0;
            r.event_res = ev;
            r.tok_type  = typ;
            r.text_byte = text;
            r.tok_value = value;
            r.tok_line  = line_no;
            r.err_code  = err;
            step.insert(step.size(), r);
        endfunction

        function void fail_tok(logic [3:0] typ, logic [1:0] err);
            put(EV_ERROR, typ, 8'd0, 32'd0, err);
            halted = 1'b1;
            mode   = M_IDLE;
        endfunction

        // Byte seen with no token open
        function void open_tok(logic [7:0] c);
            logic [3:0] pt;
            pt   = punct_kind(c);
            mode = M_IDLE;
            if (c[7]) return;
            if (ch_blank(c)) begin
                if (c == 8'd10 && line_no != LINE_MAX) line_no++;
            end else if (ch_digit(c)) begin
                mode    = M_NUM;
                num_val = 32'(c - 8'd48);
                put(EV_TEXT, TT_INT, c, 32'd0, 2'd0);
            end else if (ch_letter(c) || c == "_") begin
                mode = M_IDENT;
                put(EV_TEXT, TT_ID, c, 32'd0, 2'd0);
            end else if (c == "\"") begin
                mode = M_STR;
            end else if (c == "'") begin
                mode = M_CH_OPEN;
            end else if (pt != TT_INT) begin
                put(EV_TEXT_END, pt, c, 32'd0, 2'd0);
            end else if (ch_oper(c)) begin
                op_ch = c;
                mode  = M_OPP;
            end
        endfunction

        function void scan(logic [7:0] c);
            logic [39:0] wide;
            logic [3:0]  t;
            case (mode)
                M_NUM: begin
                    if (ch_digit(c)) begin
                        wide    = {8'd0, num_val} * 40'd10 + {32'd0, c - 8'd48};
                        num_val = (wide > 40'hFFFF_FFFF) ? '1 : wide[31:0];
                        put(EV_TEXT, TT_INT, c, 32'd0, 2'd0);
                    end else if (c == "b") begin
                        mode = M_IDLE;
                        if (num_val > BYTE_LIT_MAX) fail_tok(TT_BYTE, ERR_BYTE_RANGE);
                        else put(EV_END, TT_BYTE, 8'd0, num_val, 2'd0);
                    end else begin
                        put(EV_END, TT_INT, 8'd0, num_val, 2'd0);
                        open_tok(c);
                    end
                end
                M_IDENT: begin
                    if (ch_letter(c) || ch_digit(c) || c == "_") begin
                        put(EV_TEXT, TT_ID, c, 32'd0, 2'd0);
                    end else begin
                        put(EV_END, TT_ID, 8'd0, 32'd0, 2'd0);
                        open_tok(c);
                    end
                end
                M_STR: begin
                    if (c == "\"") begin
                        put(EV_END, TT_STR, 8'd0, 32'd0, 2'd0);
                        mode = M_IDLE;
                    end else if (!c[7]) begin
                        put(EV_TEXT, TT_STR, c, 32'd0, 2'd0);
                    end
                end
                M_OPP: begin
                    if (c == "=" || (op_ch == "|" && c == "|") || (op_ch == "&" && c == "&") ||
                        (op_ch == "-" && c == ">")) begin
                        t = (op_ch == "-" && c == ">") ? TT_ARROW : TT_OP;
                        put(EV_TEXT, t, op_ch, 32'd0, 2'd0);
                        put(EV_TEXT_END, t, c, 32'd0, 2'd0);
                        mode = M_IDLE;
                    end else begin
                        put(EV_TEXT_END, TT_OP, op_ch, 32'd0, 2'd0);
                        open_tok(c);
                    end
                end
                M_CH_OPEN: begin
                    if (!c[7]) begin
                        if (c == "\\") begin
                            mode = M_CH_ESC;
                        end else begin
                            chr_val = c;
                            mode    = M_CH_CLOSE;
                        end
                    end
                end
                M_CH_ESC: begin
                    if (!c[7]) begin
                        case (c)
                            "n": chr_val = 8'd10;
                            "t": chr_val = 8'd9;
                            "r": chr_val = 8'd13;
                            "0": chr_val = 8'd0;
                            default: chr_val = c;
                        endcase
                        mode = M_CH_CLOSE;
                    end
                end
                M_CH_CLOSE: begin
                    if (!c[7]) begin
                        if (c == "'") begin
                            put(EV_END, TT_CHAR, 8'd0, {24'd0, chr_val}, 2'd0);
                            mode = M_IDLE;
                        end else begin
                            fail_tok(TT_CHAR, ERR_CHAR_QUOTE);
                        end
                    end
                end
                default: open_tok(c);
            endcase
        endfunction

        // Accepted input transaction: queue the events it must produce
        function void take_byte(t_in x);
            step.delete();
            if (x.kind == KIND_END) begin
                if (!halted) begin
                    case (mode)
                        M_NUM:      put(EV_END, TT_INT, 8'd0, num_val, 2'd0);
                        M_IDENT:    put(EV_END, TT_ID, 8'd0, 32'd0, 2'd0);
                        M_STR:      put(EV_END, TT_STR, 8'd0, 32'd0, 2'd0);
                        M_OPP:      put(EV_TEXT_END, TT_OP, op_ch, 32'd0, 2'd0);
                        M_CH_OPEN,
                        M_CH_ESC:   put(EV_ERROR, TT_CHAR, 8'd0, 32'd0, ERR_CHAR_EOF);
                        M_CH_CLOSE: put(EV_ERROR, TT_CHAR, 8'd0, 32'd0, ERR_CHAR_QUOTE);
                        default: ;
                    endcase
                end
                put(EV_DONE, TT_INT, 8'd0, 32'd0, 2'd0);
                clear();
            end else if (!halted) begin
                scan(x.in_byte);
            end
            if (step.size() > 0) step[step.size() - 1].last = 1'b1;
            foreach (step[i]) owed.insert(owed.size(), step[i]);
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // Accepted result transaction: compare with the oldest owed event
        function void match_result(t_res got);
            t_res want;
            if (owed.size() == 0) begin
                $error("result with no event owed: event_res %0d tok_type %0d",
                       got.event_res, got.tok_type);
                mismatches++;
                return;
            end
            want = owed.pop_front();
            cmp_field("event_res", want.event_res, got.event_res);
            cmp_field("tok_type", want.tok_type, got.tok_type);
            cmp_field("text_byte", want.text_byte, got.text_byte);
            cmp_field("tok_value", want.tok_value, got.tok_value);
            cmp_field("tok_line", want.tok_line, got.tok_line);
            cmp_field("err_code", want.err_code, got.err_code);
            cmp_field("last", want.last, got.last);
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_push  = 1'b0;
    t_in  i_in    = '0;
    logic o_full;
    logic i_pop   = 1'b0;
    logic o_empty;
    t_res o_res;

    lexer_tracker lex;
    t_in          src_q[$];      // program bytes not yet offered to the lexer
    int           idle_pct  = 0; // sender gap chance per cycle, in percent
    int           stall_pct = 0; // receiver stall chance per cycle, in percent
    int           rx_calm   = 0; // cycles left in a receiver stretch without stalls
    int           quiet     = 0;

    source_token_lexer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_in    (i_in),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_res   (o_res)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Program text generation
    // ---------------------------------------------------------------
    function automatic void add_data(logic [7:0] c);
        t_in x;
        x.kind    = KIND_DATA;
        x.in_byte = c;
        src_q.insert(src_q.size(), x);
    endfunction

    // End of program; the byte field is don't-care, so randomize it
    function automatic void add_end();
        t_in x;
        x.kind    = KIND_END;
        x.in_byte = 8'($urandom_range(255));
        src_q.insert(src_q.size(), x);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_data(s[i]);
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    // String body byte: mostly printable, with newlines and high bytes mixed in
    function automatic logic [7:0] str_byte();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 8'($urandom_range(32, 126));
        if (r < 75) return 8'd10;
        if (r < 85) return 8'($urandom_range(128, 255));
        return 8'($urandom_range(255));
    endfunction

    // One token, usually well formed; a few are deliberately broken
    function automatic void add_token();
        int r;
        r = $urandom_range(99);
        if (r < 18) begin
            // number; long ones push the value into saturation
            repeat (($urandom_range(9) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 3))
                add_data(8'd48 + 8'($urandom_range(9)));
            if ($urandom_range(6) == 0) add_data("b");
        end else if (r < 34) begin
            add_data(pick("abcxyzKQ_"));
            repeat ($urandom_range(6)) add_data(pick("az_09QZbn"));
        end else if (r < 44) begin
            add_data("\"");
            repeat ($urandom_range(8)) add_data(str_byte());
            if ($urandom_range(9) != 0) add_data("\"");
        end else if (r < 54) begin
            add_data("'");
            if ($urandom_range(3) == 0) begin
                add_data("\\");
                add_data(pick("ntr0\\'q"));
            end else begin
                add_data(8'($urandom_range(127)));
            end
            // high bytes inside a char literal are dropped
            if ($urandom_range(4) == 0) add_data(8'($urandom_range(128, 255)));
            case ($urandom_range(9))
                0: add_data(8'($urandom_range(127)));   // likely a missing quote
                1: ;                                     // left open
                default: add_data("'");
            endcase
        end else if (r < 70) begin
            add_data(pick("+-*/=%|&!<>."));
            if ($urandom_range(1) == 0) add_data(pick("=|&>"));
        end else if (r < 82) begin
            add_data(pick("(){};:,[]"));
        end else begin
            add_data(8'($urandom_range(255)));       // noise
        end
    endfunction

    function automatic void add_program(int n_items);
        int stop;
        stop = src_q.size() + n_items;
        while (src_q.size() < stop) begin
            add_token();
            // whitespace between most tokens; adjacent tokens exercise closing bytes
            case ($urandom_range(3))
                0, 1: add_data(pick(" \n"));
                2: add_data(8'($urandom_range(9, 13)));
                default: ;
            endcase
            if ($urandom_range(24) == 0) add_end();
        end
        add_end();
    endfunction

    // ---------------------------------------------------------------
    // Input side: offers queued bytes with random gaps
    // ---------------------------------------------------------------
    task automatic drive_items();
        bit busy;
        bit gap;
        int calm;
        busy = 1'b0;
        calm = 0;
        while (src_q.size() > 0 || busy) begin
            @(posedge i_clk);
            if (i_push && !o_full) begin
                lex.take_byte(i_in);
                busy = 1'b0;
            end else begin
                busy = i_push;
            end
            // a transaction that is held keeps push and data untouched
            if (!busy) begin
                if (calm > 0) calm--;
                else if ($urandom_range(39) == 0) calm = $urandom_range(40);
                gap = (calm == 0) && ($urandom_range(99) < idle_pct);
                if (src_q.size() > 0 && !gap) begin
                    i_in   <= src_q.pop_front();
                    i_push <= 1'b1;
                    busy = 1'b1;
                end else begin
                    i_push <= 1'b0;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: checks every accepted result, stalls at random
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_pop && !o_empty) lex.match_result(o_res);
        if (rx_calm > 0) rx_calm--;
        else if ($urandom_range(39) == 0) rx_calm = $urandom_range(40);
        i_pop <= !(rx_calm == 0 && $urandom_range(99) < stall_pct);
    end

    // Watchdog: any transaction on either side restarts the count
    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    int idle_tbl[4]  = '{0, 83, 0, 33};
    int stall_tbl[4] = '{0, 0, 83, 33};

    initial begin
        lex = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = idle_tbl[ph];
            stall_pct = stall_tbl[ph];
            if (ph == 0) begin
                // Directed: identifier closed by an arrow, byte literal, punctuation,
                // newline count, escaped char, string with a high byte and a newline,
                // number closed by an operator, lone operator flushed by the end item,
                // then an out-of-range byte literal followed by ignored input.
                add_text("x_Z9->7b(\n'\\n'\"");
                add_data(8'hFF);
                add_text("\n\"2=");
                add_end();
                add_text("300b;");
                add_data(8'h00);
                add_end();
                drive_items();
            end
            add_program(ITEMS_PER_PHASE);
            drive_items();
        end

        // every owed event has to arrive, then let the pipeline settle
        while (lex.owed.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (lex.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
